// ===== hdl/tppg_pkg.sv =====
// shared widths, codes and divider handshake types of the test pattern generator
package tppg_pkg;

   localparam int CoordW  = 12;
   localparam int DimW    = 13;
   localparam int ValW    = 8;
   localparam int ModeW   = 2;
   localparam int CsrIdxW = 2;

   // shared serial divider
   localparam int DivW    = 26;
   localparam int DivCntW = $clog2(DivW + 1);

   // derived widths
   localparam int StepW  = CoordW;
   localparam int BrecW  = CoordW + 1;
   localparam int BarK   = CoordW;
   localparam int BarPW  = CoordW + BrecW;
   localparam int D2W    = 2 * CoordW + 1;
   localparam int RadK   = D2W;
   localparam int RrecW  = RadK + 1;
   localparam int RadPW  = D2W + RrecW;
   localparam int SqW    = 2 * DimW;
   localparam int ScaleW = SqW - 8;
   localparam int RqW    = ValW + ScaleW;
   localparam int QuartW = DimW - 2;
   localparam int DiaW   = CoordW + 2;
   localparam int FdW    = DimW + QuartW;

   localparam logic [ValW-1:0] ValMax = 8'hFF;

   // pattern select
   localparam logic [ModeW-1:0] PAT_BARS    = 2'd0;
   localparam logic [ModeW-1:0] PAT_RADIAL  = 2'd1;
   localparam logic [ModeW-1:0] PAT_BLOCK   = 2'd2;
   localparam logic [ModeW-1:0] PAT_DIAMOND = 2'd3;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_MODE   = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_HEIGHT = 2'd2;

   typedef struct packed {
      logic            start;
      logic [DivW-1:0] dividend;
      logic [DivW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic            busy;
      logic            done;
      logic [DivW-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== hdl/tppg_ifs.sv =====
// valid/ready channels for pixel coordinates and pixel values
interface tppg_req_if import tppg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CoordW-1:0] pixel_x;
   logic [CoordW-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface tppg_rsp_if import tppg_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [ValW-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink (input valid, input pixel_value, output ready);
endinterface

// ===== hdl/tppg_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module tppg_div import tppg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DivW-1:0]    quo_ff, quo_in;
   logic [DivW-1:0]    rem_ff, rem_in;
   logic [DivW-1:0]    den_ff, den_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DivW:0]      trial;
   logic [DivW:0]      diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DivW-1]};
      diff    = trial - {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = DivCntW'(DivW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DivW]) begin
            rem_in = diff[DivW-1:0];
            quo_in = {quo_ff[DivW-2:0], 1'b1};
         end else begin
            rem_in = trial[DivW-1:0];
            quo_in = {quo_ff[DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DivCntW'(1);
         if (cnt_ff == DivCntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== hdl/test_pattern_pixel_generator.sv =====
// top level: four-pattern video test pixel generator with frame setup sequencer
// an accepted coordinate beat passes stages a to e and the output register to rsp
// throughput: one pixel per clock, set by the six-stage pixel pipeline, unless rsp stalls
// after reset and after every csr write a setup pass runs
// (three divisions on the shared serial divider); req_bus.ready is low meanwhile
// reset is synchronous active high: registers go to mode 0 and a 256 x 256 frame
module test_pattern_pixel_generator import tppg_pkg::*; #(
   parameter int MAX_DIM    = 4096,
   parameter int BAR_LEVELS = 16
) (
   input  logic               clock,
   input  logic               reset,
   tppg_req_if.sink           req_bus,
   tppg_rsp_if.source         rsp_bus,
   input  logic               csr_write,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [DimW-1:0]    csr_data
);

   // frame dimension cap, limited to what the register can hold
   localparam logic [DimW-1:0] DimCap =
      (MAX_DIM >= (1 << DimW) - 1) ? DimW'((1 << DimW) - 1) : DimW'(MAX_DIM);
   localparam logic [8:0]      BarMult = 9'(256 / BAR_LEVELS);
   localparam logic [DivW-1:0] BrecNum = DivW'(1 << BarK);
   localparam logic [DivW-1:0] RrecNum = DivW'(1 << RadK);
   // bar height by reciprocal, exact for any 13-bit height and up to 256 levels
   localparam int              StepK     = DimW + 8;
   localparam logic [StepK-1:0] StepRecip =
      StepK'(((1 << StepK) + BAR_LEVELS - 1) / BAR_LEVELS);

   // setup sequencer states
   localparam logic [2:0] ST_CLAMP    = 3'd0;
   localparam logic [2:0] ST_GEOM     = 3'd1;
   localparam logic [2:0] ST_SQH      = 3'd2;
   localparam logic [2:0] ST_SQW      = 3'd3;
   localparam logic [2:0] ST_SCALE    = 3'd4;
   localparam logic [2:0] ST_DIV_GO   = 3'd5;
   localparam logic [2:0] ST_DIV_WAIT = 3'd6;
   localparam logic [2:0] ST_READY    = 3'd7;

   // which division the shared divider is running
   localparam logic [1:0] DIV_BREC = 2'd1;
   localparam logic [1:0] DIV_FRAT = 2'd2;
   localparam logic [1:0] DIV_RREC = 2'd3;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [ModeW-1:0] mode_ff;
   logic [DimW-1:0]  fw_ff;
   logic [DimW-1:0]  fh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= PAT_BARS;
         fw_ff   <= DimW'(256);
         fh_ff   <= DimW'(256);
      end else if (csr_write) begin
         case (csr_index)
            CSR_MODE:   mode_ff <= csr_data[ModeW-1:0];
            CSR_WIDTH:  fw_ff   <= csr_data;
            CSR_HEIGHT: fh_ff   <= csr_data;
            default:    ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // frame setup: geometry, squares, bar height and the three divisions
   // ---------------------------------------------------------------
   logic [2:0]              state_ff;
   logic [1:0]              div_sel_ff;
   logic [DimW-1:0]         w_ff, h_ff;
   logic [CoordW-1:0]       cx_ff, cy_ff;
   logic [DimW-1:0]         dw_ff, dh_ff;
   logic [QuartW-1:0]       wq_ff, hq_ff;
   logic [DimW-1:0]         w3q_ff, h3q_ff;
   logic signed [DiaW-1:0]  h3m1_ff;
   logic [SqW-1:0]          sq_ff;
   logic [ScaleW-1:0]       scale_ff;
   logic [StepW-1:0]        step_ff;
   logic [BrecW-1:0]        brec_ff;
   logic [DimW-1:0]         frat_ff;
   logic [RrecW-1:0]        rrec_ff;
   logic [DimW+1:0]         w3_sum, h3_sum;
   logic [SqW-1:0]          sqh_prod, sqw_prod;
   logic [DimW+StepK-1:0]   step_prod;
   logic                    setup_ok;
   div_req_type             div_req;
   div_rsp_type             div_rsp;

   // three quarters of the frame is (3 * dim) / 4
   assign w3_sum    = {2'b00, w_ff} + {1'b0, w_ff, 1'b0};
   assign h3_sum    = {2'b00, h_ff} + {1'b0, h_ff, 1'b0};
   assign sqh_prod  = SqW'(dh_ff) * SqW'(dh_ff);
   assign sqw_prod  = SqW'(dw_ff) * SqW'(dw_ff);
   assign step_prod = (DimW + StepK)'(h_ff) * (DimW + StepK)'(StepRecip);
   assign setup_ok  = (state_ff == ST_READY);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLAMP;
         div_sel_ff <= DIV_BREC;
      end else if (csr_write) begin
         // any register change redoes the whole setup
         state_ff <= ST_CLAMP;
      end else begin
         case (state_ff)
            ST_CLAMP: begin
               w_ff     <= (fw_ff > DimCap) ? DimCap : fw_ff;
               h_ff     <= (fh_ff > DimCap) ? DimCap : fh_ff;
               state_ff <= ST_GEOM;
            end
            ST_GEOM: begin
               cx_ff    <= w_ff[DimW-1:1];
               cy_ff    <= h_ff[DimW-1:1];
               dw_ff    <= w_ff - {1'b0, w_ff[DimW-1:1]};
               dh_ff    <= h_ff - {1'b0, h_ff[DimW-1:1]};
               wq_ff    <= w_ff[DimW-1:2];
               hq_ff    <= h_ff[DimW-1:2];
               w3q_ff   <= w3_sum[DimW+1:2];
               h3q_ff   <= h3_sum[DimW+1:2];
               // last row of the lower diamond half, may be -1 on tiny frames
               h3m1_ff  <= {1'b0, h3_sum[DimW+1:2]} - DiaW'(1);
               state_ff <= ST_SQH;
            end
            ST_SQH: begin
               sq_ff    <= sqh_prod;
               state_ff <= ST_SQW;
            end
            ST_SQW: begin
               sq_ff    <= sq_ff + sqw_prod;
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               // gradient divisor and bar height, never below one
               scale_ff   <= (sq_ff[SqW-1:8] == '0) ? ScaleW'(1) : sq_ff[SqW-1:8];
               step_ff    <= (step_prod[DimW+StepK-1:StepK] == '0) ? StepW'(1) :
                             step_prod[StepW+StepK-1:StepK];
               div_sel_ff <= DIV_BREC;
               state_ff   <= ST_DIV_GO;
            end
            ST_DIV_GO: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_rsp.done) begin
                  case (div_sel_ff)
                     DIV_BREC: brec_ff <= div_rsp.quotient[BrecW-1:0];
                     // zero height lights no diamond pixel
                     DIV_FRAT: frat_ff <= (h_ff == '0) ? '0 :
                                          div_rsp.quotient[DimW-1:0];
                     DIV_RREC: rrec_ff <= div_rsp.quotient[RrecW-1:0];
                     default:  ;
                  endcase
                  if (div_sel_ff == DIV_RREC) begin
                     state_ff <= ST_READY;
                  end else begin
                     div_sel_ff <= div_sel_ff + 2'd1;
                     state_ff   <= ST_DIV_GO;
                  end
               end
            end
            ST_READY: state_ff <= ST_READY;
            default:  state_ff <= ST_CLAMP;
         endcase
      end
   end

   // divider operands: bar reciprocal, width ratio, gradient reciprocal
   always_comb begin
      div_req.start = (state_ff == ST_DIV_GO);
      case (div_sel_ff)
         DIV_BREC: begin
            div_req.dividend = BrecNum;
            div_req.divisor  = DivW'(step_ff);
         end
         DIV_FRAT: begin
            div_req.dividend = DivW'(w_ff);
            div_req.divisor  = DivW'(h_ff);
         end
         default: begin
            div_req.dividend = RrecNum;
            div_req.divisor  = DivW'(scale_ff);
         end
      endcase
   end

   tppg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // ---------------------------------------------------------------
   // pixel pipeline: stages a, b, c, d, e and the output register
   // each stage moves on when the next one is empty or moving
   // ---------------------------------------------------------------
   logic [5:0] vld_ff, vld_in;
   logic [5:0] free;
   logic [5:0] ld;
   logic       take_in;

   always_comb begin
      free[5] = !vld_ff[5] || rsp_bus.ready;
      for (int k = 4; k >= 0; k--) begin
         free[k] = !vld_ff[k] || free[k+1];
      end
   end

   assign req_bus.ready = setup_ok && free[0];
   assign take_in       = req_bus.valid && req_bus.ready;

   always_comb begin
      ld[0]     = take_in;
      vld_in[0] = free[0] ? take_in : vld_ff[0];
      for (int k = 1; k < 6; k++) begin
         ld[k]     = free[k] && vld_ff[k-1];
         vld_in[k] = free[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage a: coordinate capture
   logic [CoordW-1:0] x_a_ff, y_a_ff;
   logic [ModeW-1:0]  mode_a_ff;

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         x_a_ff    <= req_bus.pixel_x;
         y_a_ff    <= req_bus.pixel_y;
         mode_a_ff <= mode_ff;
      end
   end

   // stage b: distances to center, bar quotient estimate, diamond rows, block test
   logic [CoordW-1:0]      dx_b_in, dy_b_in, qb_b_in;
   logic [BarPW-1:0]       barp;
   logic signed [DiaW-1:0] d1_c, d2_c;
   logic                   ok1_b_in, ok2_b_in, blk_b_in;
   logic [QuartW-1:0]      dd1_b_in, dd2_b_in;
   logic [CoordW-1:0]      dx_b_ff, dy_b_ff, qb_b_ff, x_b_ff, y_b_ff;
   logic                   ok1_b_ff, ok2_b_ff, blk_b_ff;
   logic [QuartW-1:0]      dd1_b_ff, dd2_b_ff;
   logic [ModeW-1:0]       mode_b_ff;

   always_comb begin
      dx_b_in  = (x_a_ff >= cx_ff) ? x_a_ff - cx_ff : cx_ff - x_a_ff;
      dy_b_in  = (y_a_ff >= cy_ff) ? y_a_ff - cy_ff : cy_ff - y_a_ff;
      // y * floor(4096 / step) / 4096 is the quotient or one short
      barp     = BarPW'(y_a_ff) * BarPW'(brec_ff);
      qb_b_in  = barp[BarK+CoordW-1:BarK];
      // row offset inside the upper and the lower diamond half
      d1_c     = $signed({2'b00, y_a_ff}) - $signed({3'b000, hq_ff});
      d2_c     = h3m1_ff - $signed({2'b00, y_a_ff});
      ok1_b_in = !d1_c[DiaW-1] && (d1_c < $signed({3'b000, hq_ff}));
      ok2_b_in = !d2_c[DiaW-1] && (d2_c < $signed({3'b000, hq_ff}));
      dd1_b_in = ok1_b_in ? d1_c[QuartW-1:0] : '0;
      dd2_b_in = ok2_b_in ? d2_c[QuartW-1:0] : '0;
      blk_b_in = ({1'b0, y_a_ff} >= {2'b00, hq_ff}) && ({1'b0, y_a_ff} < h3q_ff) &&
                 ({1'b0, x_a_ff} >= {2'b00, wq_ff}) && ({1'b0, x_a_ff} < w3q_ff);
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         dx_b_ff   <= dx_b_in;
         dy_b_ff   <= dy_b_in;
         qb_b_ff   <= qb_b_in;
         x_b_ff    <= x_a_ff;
         y_b_ff    <= y_a_ff;
         ok1_b_ff  <= ok1_b_in;
         ok2_b_ff  <= ok2_b_in;
         dd1_b_ff  <= dd1_b_in;
         dd2_b_ff  <= dd2_b_in;
         blk_b_ff  <= blk_b_in;
         mode_b_ff <= mode_a_ff;
      end
   end

   // stage c: squared distance, bar back-multiply, diamond half-widths
   logic [D2W-1:0]      d2_c_in;
   logic [2*CoordW-1:0] bp;
   logic [CoordW-1:0]   bprod_c_in;
   logic [FdW-1:0]      fd1_c_in, fd2_c_in;
   logic [D2W-1:0]      d2_c_ff;
   logic [CoordW-1:0]   bprod_c_ff, qb_c_ff, x_c_ff, y_c_ff;
   logic [FdW-1:0]      fd1_c_ff, fd2_c_ff;
   logic                ok1_c_ff, ok2_c_ff, blk_c_ff;
   logic [ModeW-1:0]    mode_c_ff;

   always_comb begin
      d2_c_in    = D2W'(dx_b_ff) * D2W'(dx_b_ff) + D2W'(dy_b_ff) * D2W'(dy_b_ff);
      // estimate never exceeds the quotient, so the product does not exceed y
      bp         = (2 * CoordW)'(qb_b_ff) * (2 * CoordW)'(step_ff);
      bprod_c_in = bp[CoordW-1:0];
      fd1_c_in   = FdW'(frat_ff) * FdW'(dd1_b_ff);
      fd2_c_in   = FdW'(frat_ff) * FdW'(dd2_b_ff);
   end

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         d2_c_ff    <= d2_c_in;
         bprod_c_ff <= bprod_c_in;
         qb_c_ff    <= qb_b_ff;
         x_c_ff     <= x_b_ff;
         y_c_ff     <= y_b_ff;
         fd1_c_ff   <= fd1_c_in;
         fd2_c_ff   <= fd2_c_in;
         ok1_c_ff   <= ok1_b_ff;
         ok2_c_ff   <= ok2_b_ff;
         blk_c_ff   <= blk_b_ff;
         mode_c_ff  <= mode_b_ff;
      end
   end

   // stage d: gradient quotient estimate, bar level, diamond and block values
   logic [RadPW-1:0]  rp;
   logic [RrecW-1:0]  qr_full;
   logic              big_d_in;
   logic [CoordW-1:0] rb;
   logic [ValW-1:0]   qbf8;
   logic [ValW+8:0]   bm;
   logic [FdW:0]      xe, cxe, fd1e, fd2e;
   logic              lit;
   logic [ValW-1:0]   oval_d_in;
   logic [D2W-1:0]    d2_d_ff;
   logic              big_d_ff, isrd_d_ff;
   logic [ValW-1:0]   qr_d_ff, oval_d_ff;

   always_comb begin
      rp       = RadPW'(d2_c_ff) * RadPW'(rrec_ff);
      qr_full  = rp[RadPW-1:RadK];
      // estimate at or above 255 means the clamped value is zero
      big_d_in = (qr_full >= RrecW'(ValMax));
      // bar quotient correction, only the low byte reaches the output
      rb       = y_c_ff - bprod_c_ff;
      qbf8     = qb_c_ff[ValW-1:0] + ValW'(rb >= step_ff);
      bm       = (ValW + 9)'(qbf8) * (ValW + 9)'(BarMult);
      xe       = (FdW + 1)'(x_c_ff);
      cxe      = (FdW + 1)'(cx_ff);
      fd1e     = (FdW + 1)'(fd1_c_ff);
      fd2e     = (FdW + 1)'(fd2_c_ff);
      lit      = (ok1_c_ff && (xe + fd1e >= cxe) && (xe < cxe + fd1e)) ||
                 (ok2_c_ff && (xe + fd2e >= cxe) && (xe < cxe + fd2e));
      case (mode_c_ff)
         PAT_BARS:    oval_d_in = bm[ValW-1:0];
         PAT_BLOCK:   oval_d_in = blk_c_ff ? ValMax : '0;
         PAT_DIAMOND: oval_d_in = lit ? ValMax : '0;
         default:     oval_d_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         d2_d_ff   <= d2_c_ff;
         big_d_ff  <= big_d_in;
         qr_d_ff   <= qr_full[ValW-1:0];
         oval_d_ff <= oval_d_in;
         isrd_d_ff <= (mode_c_ff == PAT_RADIAL);
      end
   end

   // stage e: gradient back-multiply
   logic [RqW-1:0]  rq_e_in;
   logic [RqW-1:0]  rq_e_ff;
   logic [D2W-1:0]  d2_e_ff;
   logic            big_e_ff, isrd_e_ff;
   logic [ValW-1:0] qr_e_ff, oval_e_ff;

   assign rq_e_in = RqW'(qr_d_ff) * RqW'(scale_ff);

   always_ff @(posedge clock) begin
      if (ld[4]) begin
         rq_e_ff   <= rq_e_in;
         d2_e_ff   <= d2_d_ff;
         big_e_ff  <= big_d_ff;
         qr_e_ff   <= qr_d_ff;
         oval_e_ff <= oval_d_ff;
         isrd_e_ff <= isrd_d_ff;
      end
   end

   // output register: gradient correction and final select
   logic [D2W-1:0]  rr;
   logic [ValW-1:0] qf;
   logic [ValW-1:0] radv;
   logic [ValW-1:0] val_o_in;
   logic [ValW-1:0] val_o_ff;

   always_comb begin
      rr       = d2_e_ff - rq_e_ff[D2W-1:0];
      qf       = qr_e_ff + ValW'(rr >= D2W'(scale_ff));
      radv     = big_e_ff ? '0 : ValMax - qf;
      val_o_in = isrd_e_ff ? radv : oval_e_ff;
   end

   always_ff @(posedge clock) begin
      if (ld[5]) begin
         val_o_ff <= val_o_in;
      end
   end

   assign rsp_bus.valid       = vld_ff[5];
   assign rsp_bus.pixel_value = val_o_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // a register write closes the input until setup has run again
   a_cfg_closes_input: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> !req_bus.ready)
      else $error("input open right after a register write");

   // both per-pixel divisors are nonzero once setup is done
   a_divisors_set: assert property (@(posedge clock) disable iff (reset)
      setup_ok |-> ((step_ff != '0) && (scale_ff != '0)))
      else $error("zero divisor after setup");

   // a saturated gradient beat leaves as zero
   a_radial_sat: assert property (@(posedge clock) disable iff (reset)
      (ld[5] && isrd_e_ff && big_e_ff) |=> (rsp_bus.pixel_value == '0))
      else $error("saturated gradient pixel not zero");

   // a held beat in stage e is not dropped while the output is blocked
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[4] && !free[5]) |=> vld_ff[4])
      else $error("pipeline beat lost under stall");

endmodule

// ===== verif/tb_top.sv =====
// testbench for the test pattern pixel generator: scoreboard, stimulus and response checking
`timescale 1ns / 1ps

module tb_top;
   import tppg_pkg::*;

   // block parameters, kept at their defaults
   localparam int MAX_DIM    = 4096;
   localparam int BAR_LEVELS = 16;

   // register index past the end of the register list, writes to it are dropped
   localparam logic [CsrIdxW-1:0] CSR_SPARE = 2'd3;

   // cycles to let pass once the last value beat is in, before a csr write or the end
   localparam int SETTLE = 12;

   // items of the random part, spread over several frame settings
   localparam int RAND_PHASES    = 12;
   localparam int ITEMS_PER_PHASE = 103;

   // beats seen on rsp before the long receiver hold-off, and its length in cycles
   localparam int HOLD_AFTER = 700;
   localparam int HOLD_LEN   = 400;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_type;

   // pixel value predictor plus the queue of values still owed by the block
   class pixel_scoreboard;
      logic [ModeW-1:0] mode;
      int unsigned      width;
      int unsigned      height;
      logic [ValW-1:0]  level_q[$];
      int               errors;

      function new();
         mode   = PAT_BARS;
         width  = 256;
         height = 256;
         errors = 0;
      endfunction

      function void set_reg(logic [CsrIdxW-1:0] idx, logic [DimW-1:0] data);
         case (idx)
            CSR_MODE:   mode = data[ModeW-1:0];
            CSR_WIDTH:  width = 32'(data);
            CSR_HEIGHT: height = 32'(data);
            default: ;
         endcase
      endfunction

      // one diamond row: d counts rows from the tip of a half
      function bit diamond_lit(longint x, longint d, longint q, longint cx, longint f);
         if (d < 0 || d >= q)
            return 1'b0;
         return x >= cx - f * d && x < cx + f * d;
      endfunction

      function logic [ValW-1:0] pixel_level(logic [CoordW-1:0] px, logic [CoordW-1:0] py);
         longint x, y, w, h, cx, cy, step, scale, d2, v, f, q;
         x = longint'(px);
         y = longint'(py);
         w = longint'((width > MAX_DIM) ? MAX_DIM : width);
         h = longint'((height > MAX_DIM) ? MAX_DIM : height);
         v = 0;
         case (mode)
            PAT_BARS: begin
               step = h / BAR_LEVELS;
               if (step == 0)
                  step = 1;
               v = ((y / step) * (256 / BAR_LEVELS)) & 255;
            end
            PAT_RADIAL: begin
               cx    = w / 2;
               cy    = h / 2;
               scale = ((h - cy) * (h - cy) + (w - cx) * (w - cx)) / 256;
               if (scale == 0)
                  scale = 1;
               d2 = (x - cx) * (x - cx) + (y - cy) * (y - cy);
               v  = 255 - d2 / scale;
               if (v < 0)
                  v = 0;
               if (v > 255)
                  v = 255;
            end
            PAT_BLOCK: begin
               if (y >= h / 4 && y < (3 * h) / 4 && x >= w / 4 && x < (3 * w) / 4)
                  v = 255;
            end
            default: begin
               if (h != 0) begin
                  f  = w / h;
                  q  = h / 4;
                  cx = w / 2;
                  if (diamond_lit(x, y - q, q, cx, f) ||
                      diamond_lit(x, (3 * h) / 4 - 1 - y, q, cx, f))
                     v = 255;
               end
            end
         endcase
         return v[ValW-1:0];
      endfunction

      function void note_pixel(logic [CoordW-1:0] px, logic [CoordW-1:0] py);
         level_q.push_back(pixel_level(px, py));
      endfunction

      function void check_value(logic [ValW-1:0] actual);
         logic [ValW-1:0] want;
         if (level_q.size() == 0) begin
            $error("pixel_value beat with nothing outstanding: actual %0d", actual);
            errors++;
            return;
         end
         want = level_q.pop_front();
         if (actual !== want) begin
            $error("pixel_value mismatch: expected %0d, actual %0d", want, actual);
            errors++;
         end
      endfunction

      function int pending();
         return level_q.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write;
   logic [CsrIdxW-1:0] csr_index;
   logic [DimW-1:0]    csr_data;

   tppg_req_if req_bus();
   tppg_rsp_if rsp_bus();

   pixel_scoreboard sb = new();

   test_pattern_pixel_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   // offer one coordinate beat and hold it until the block takes it;
   // valid stays high on return so back-to-back beats need no extra edge
   task automatic send_pixel(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
      req_bus.valid   <= 1'b1;
      req_bus.pixel_x <= x;
      req_bus.pixel_y <= y;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      sb.note_pixel(x, y);
   endtask

   // stop offering, wait for every owed value, then give the pipe a few spare cycles
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // one register write per edge; the caller drops csr_write after the batch
   task automatic csr_put(input logic [CsrIdxW-1:0] idx, input logic [DimW-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      sb.set_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic apply_frame(input logic [ModeW-1:0] mode, input int unsigned w,
                              input int unsigned h);
      drain();
      csr_put(CSR_MODE, DimW'(mode));
      csr_put(CSR_WIDTH, w[DimW-1:0]);
      csr_put(CSR_HEIGHT, h[DimW-1:0]);
      csr_write <= 1'b0;
   endtask

   // frame dimension for a random phase: mostly legal, sometimes tiny or oversized
   function automatic int unsigned pick_dim();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return $urandom_range(MAX_DIM + 1, 8191);
      if (r == 1)
         return $urandom_range(0, 31);
      return $urandom_range(32, MAX_DIM);
   endfunction

   // coordinate along a dimension: mostly inside the frame, some on the pattern
   // edges (quarters, centre, last pixel), and a few anywhere in the field
   function automatic logic [CoordW-1:0] pick_coord(input int unsigned dim);
      int unsigned span;
      int          c;
      int unsigned r;
      span = (dim == 0 || dim > MAX_DIM) ? MAX_DIM : dim;
      r    = $urandom_range(0, 15);
      if (r == 0)
         return CoordW'($urandom_range(0, 4095));
      if (r < 4) begin
         case ($urandom_range(0, 5))
            0: c = span / 4 - 1;
            1: c = span / 4;
            2: c = (3 * span) / 4 - 1;
            3: c = (3 * span) / 4;
            4: c = span / 2 + $urandom_range(0, 4) - 2;
            default: c = span - 1;
         endcase
         return c[CoordW-1:0];
      end
      return CoordW'($urandom_range(0, span - 1));
   endfunction

   // bursts of back-to-back beats separated by random gaps, some long bursts
   task automatic random_pixels(input int count);
      int left, burst, gap;
      left = count;
      while (left > 0) begin
         burst = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 24);
         for (int i = 0; i < burst && left > 0; i++) begin
            send_pixel(pick_coord(sb.width), pick_coord(sb.height));
            left--;
         end
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // receiver: picks a stall style for a random stretch of cycles, and once,
   // after enough beats, holds ready low long enough for the block to back up
   initial begin : rsp_side
      stall_style_type style;
      int              span;
      int              hold_left;
      int unsigned     beats;
      bit              held;
      style          = STALL_NONE;
      span           = 0;
      hold_left      = 0;
      beats          = 0;
      held           = 1'b0;
      rsp_bus.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            sb.check_value(rsp_bus.pixel_value);
            beats++;
         end
         if (!held && beats >= HOLD_AFTER) begin
            held      = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (span == 0) begin
               style = stall_style_type'($urandom_range(0, 3));
               span  = $urandom_range(8, 80);
            end
            span--;
            case (style)
               STALL_NONE:  rsp_bus.ready <= 1'b1;
               STALL_LIGHT: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               STALL_HEAVY: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
               default:     rsp_bus.ready <= (span % 3 != 0);
            endcase
         end
      end
   end

   // main stimulus
   initial begin
      int unsigned w, h;
      reset           = 1'b1;
      csr_write       = 1'b0;
      csr_index       = CSR_MODE;
      csr_data        = '0;
      req_bus.valid   = 1'b0;
      req_bus.pixel_x = '0;
      req_bus.pixel_y = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: gray bars on a 256 x 256 frame, coordinate extremes,
      // the second one far outside the frame
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd100, 12'd17);

      // radial gradient on the largest frame: centre, two corners, bottom edge
      apply_frame(PAT_RADIAL, MAX_DIM, MAX_DIM);
      send_pixel(12'd2048, 12'd2048);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd2047, 12'd4095);

      // centred block with oversized dimensions, clamped to the max frame;
      // probe both sides of both block corners
      apply_frame(PAT_BLOCK, 8191, 8191);
      send_pixel(12'd1023, 12'd1023);
      send_pixel(12'd1024, 12'd1024);
      send_pixel(12'd3071, 12'd3071);
      send_pixel(12'd3072, 12'd3072);

      // diamond on a 64 x 32 frame: width ratio 2, edges of the second row
      // of each half
      apply_frame(PAT_DIAMOND, 64, 32);
      send_pixel(12'd31, 12'd9);
      send_pixel(12'd29, 12'd9);
      send_pixel(12'd33, 12'd22);
      send_pixel(12'd34, 12'd22);

      // bars with a frame shorter than the bar count: bar height would fall to zero and is held at one
      apply_frame(PAT_BARS, 256, 10);
      send_pixel(12'd5, 12'd7);
      send_pixel(12'd5, 12'd4095);

      // radial gradient on a frame so small the scale divisor would be zero and is held at one
      apply_frame(PAT_RADIAL, 10, 10);
      send_pixel(12'd5, 12'd5);
      send_pixel(12'd0, 12'd0);

      // diamond with zero height lights nothing
      apply_frame(PAT_DIAMOND, 64, 0);
      send_pixel(12'd32, 12'd0);

      // write to an index past the register list must change nothing
      drain();
      csr_put(CSR_SPARE, 13'h1FFF);
      csr_write <= 1'b0;
      send_pixel(12'd32, 12'd5);

      // random part: the first four settings sweep the dimension extremes,
      // later ones are random; the mode rotates so each pattern sees each kind
      for (int p = 0; p < RAND_PHASES; p++) begin
         case (p)
            0: begin w = 32;      h = 32;      end
            1: begin w = MAX_DIM; h = MAX_DIM; end
            2: begin w = MAX_DIM; h = 32;      end
            3: begin w = 32;      h = MAX_DIM; end
            default: begin w = pick_dim(); h = pick_dim(); end
         endcase
         apply_frame(p[ModeW-1:0], w, h);
         random_pixels(ITEMS_PER_PHASE);
      end

      drain();
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/tppg_pkg.sv
hdl/tppg_ifs.sv
hdl/tppg_div.sv
hdl/test_pattern_pixel_generator.sv
verif/tb_top.sv
